FILE: rtl/gip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid influence propagation block.
// No dependencies.
package gip_pkg;

    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q15 = 32768;

    // command codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PASS  = 2'd2;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_PASS = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_X_CELLS       = 3'd0;
    localparam logic [2:0] REG_Y_CELLS       = 3'd1;
    localparam logic [2:0] REG_Z_CELLS       = 3'd2;
    localparam logic [2:0] REG_INERTIA       = 3'd3;
    localparam logic [2:0] REG_WEIGHT_FACE   = 3'd4;
    localparam logic [2:0] REG_WEIGHT_EDGE   = 3'd5;
    localparam logic [2:0] REG_WEIGHT_CORNER = 3'd6;

    typedef logic signed [15:0] val_t;
    typedef logic signed [17:0] wval_t;   // weighted neighbor value

    typedef struct packed {
        val_t  old_value;
        wval_t pos;
        wval_t neg;
        logic  cell_used;
    } blend_in_t;

    function automatic val_t clamp_q14(input val_t v);
        if (v > 16'sd16384)
            return 16'sd16384;
        else if (v < -16'sd16384)
            return -16'sd16384;
        else
            return v;
    endfunction

    function automatic logic [15:0] clamp_q15(input logic [15:0] v);
        return (v > 16'd32768) ? 16'd32768 : v;
    endfunction

endpackage

FILE: rtl/grid_influence_propagation.sv
`timescale 1ns / 1ps
// Top level of the 3D influence grid: cell memories, update pass sequencer.
// Depends on gip_pkg and gip_blend.

// After reset the block clears its memories, all CELLS * 2^LW influence entries
// (16384 at the default size), with busy high. Cell writes and reads may follow
// back to back; read data comes with done in the cycle after start.
// In an update pass over N grid cells, every cell reads its 27 neighbors one per
// cycle through the single read port of the influence memory, drains the two-stage
// weight pipeline, then registers the blend products in ST_MUL and stores the new
// value in ST_SUM; a copy sweep over the N cells and a finish state follow.
// done is high for exactly one cycle per result and cannot be held off.
module grid_influence_propagation
    import gip_pkg::*;
#(
    parameter int MAX_DIM = 16,
    parameter int LAYERS  = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [1:0]  layer,
    input  logic [11:0] cell_index,
    input  logic        cell_used,
    input  val_t        cell_value,
    output logic        done,
    output logic        kind,
    output val_t        read_value,
    output logic        read_used
);

    localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int AW    = CW + LW;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int SW    = CW + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_COPY  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    // configuration
    logic [4:0]  x_cells_reg, y_cells_reg, z_cells_reg;
    logic [15:0] inertia_reg, weight_face_reg, weight_edge_reg, weight_corner_reg;

    // memories
    val_t infl_mem [0:(1 << AW) - 1];
    logic used_mem [0:CELLS - 1];
    val_t next_mem [0:CELLS - 1];
    val_t infl_q;
    logic used_q;
    val_t next_q;

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [DW-1:0] nx_reg, ny_reg, nz_reg;
    logic [CW:0]   plane_reg;
    logic [DW-1:0] x_reg, y_reg, z_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]    dxc_reg, dyc_reg, dzc_reg;
    logic [LW-1:0] layer_reg;
    logic [15:0]   wf_reg, we_reg, wc_reg, in_reg;

    logic          s1_vld_reg, s1_ctr_reg, s1_last_reg;
    logic [1:0]    s1_far_reg;
    logic          s2_vld_reg, s2_last_reg;
    logic signed [32:0] prod_reg;
    wval_t         pos_reg, neg_reg;
    val_t          old_reg;
    logic          cused_reg;

    logic          cp_vld_reg;
    logic [CW-1:0] cp_addr_reg;

    logic          rdv_reg, rd_cell_ok_reg, rd_layer_ok_reg, fin_reg;

    // derived
    logic          accept;
    logic          cell_ok, layer_ok;
    logic [CW-1:0] cell_addr;
    logic [LW-1:0] layer_addr;
    logic [DW-1:0] nx_eff, ny_eff, nz_eff;
    logic          nb_in;
    logic signed [SW-1:0] nidx_full, offx, offy, offz;
    logic [CW-1:0] nidx;
    logic [1:0]    far;
    logic          nb_last, cell_last;
    logic [15:0]   w_sel;
    wval_t         wv;
    val_t          blend_res;
    blend_in_t     bin;

    logic          infl_we;
    logic [AW-1:0] infl_waddr, infl_raddr;
    val_t          infl_wdata;
    logic          used_we;
    logic [CW-1:0] used_waddr, used_raddr;
    logic          used_wdata;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign cell_ok    = 32'(cell_index) < CELLS;
    assign layer_ok   = 32'(layer) < LAYERS;
    assign cell_addr  = CW'(cell_index);
    assign layer_addr = LW'(layer);

    assign nx_eff = (x_cells_reg == 5'd0) ? DW'(1) :
                    (32'(x_cells_reg) > MAX_DIM) ? DW'(MAX_DIM) : DW'(x_cells_reg);
    assign ny_eff = (y_cells_reg == 5'd0) ? DW'(1) :
                    (32'(y_cells_reg) > MAX_DIM) ? DW'(MAX_DIM) : DW'(y_cells_reg);
    assign nz_eff = (z_cells_reg == 5'd0) ? DW'(1) :
                    (32'(z_cells_reg) > MAX_DIM) ? DW'(MAX_DIM) : DW'(z_cells_reg);

    // neighbor address and grid check; codes 0,1,2 stand for -1,0,+1
    always_comb
    begin
        nb_in = 1'b1;
        if (dxc_reg == 2'd0 && x_reg == '0)
            nb_in = 1'b0;
        if (dxc_reg == 2'd2 && ({1'b0, x_reg} + 1'b1) >= {1'b0, nx_reg})
            nb_in = 1'b0;
        if (dyc_reg == 2'd0 && y_reg == '0)
            nb_in = 1'b0;
        if (dyc_reg == 2'd2 && ({1'b0, y_reg} + 1'b1) >= {1'b0, ny_reg})
            nb_in = 1'b0;
        if (dzc_reg == 2'd0 && z_reg == '0)
            nb_in = 1'b0;
        if (dzc_reg == 2'd2 && ({1'b0, z_reg} + 1'b1) >= {1'b0, nz_reg})
            nb_in = 1'b0;
    end

    always_comb
    begin
        offx = (dxc_reg == 2'd0) ? -SW'(1) : (dxc_reg == 2'd2) ? SW'(1) : '0;
        offy = (dyc_reg == 2'd0) ? -$signed(SW'(nx_reg)) :
               (dyc_reg == 2'd2) ? $signed(SW'(nx_reg)) : '0;
        offz = (dzc_reg == 2'd0) ? -$signed(SW'(plane_reg)) :
               (dzc_reg == 2'd2) ? $signed(SW'(plane_reg)) : '0;
        nidx_full = $signed(SW'(idx_reg)) + offx + offy + offz;
    end

    assign nidx    = nidx_full[CW-1:0];
    assign far     = 2'({1'b0, dxc_reg != 2'd1}) + 2'({1'b0, dyc_reg != 2'd1})
                   + 2'({1'b0, dzc_reg != 2'd1});
    assign nb_last = (dxc_reg == 2'd2) && (dyc_reg == 2'd2) && (dzc_reg == 2'd2);
    assign cell_last = (32'(x_reg) + 1 == 32'(nx_reg)) && (32'(y_reg) + 1 == 32'(ny_reg))
                     && (32'(z_reg) + 1 == 32'(nz_reg));

    always_comb
    begin
        case (s1_far_reg)
            2'd0:    w_sel = 16'd32768;
            2'd1:    w_sel = wf_reg;
            2'd2:    w_sel = we_reg;
            default: w_sel = wc_reg;
        endcase
    end

    assign wv = prod_reg[32:15];   // floor divide by 2^15

    // memory port muxes
    always_comb
    begin
        infl_we    = 1'b0;
        infl_waddr = {cell_addr, layer_addr};
        infl_wdata = clamp_q14(cell_value);
        used_we    = 1'b0;
        used_waddr = cell_addr;
        used_wdata = cell_used;
        if (state_reg == ST_CLEAR)
        begin
            infl_we    = 1'b1;
            infl_waddr = clr_cnt_reg;
            infl_wdata = '0;
            used_we    = 1'b1;
            used_waddr = clr_cnt_reg[AW-1:LW];
            used_wdata = 1'b0;
        end
        else if (cp_vld_reg)
        begin
            infl_we    = 1'b1;
            infl_waddr = {cp_addr_reg, layer_reg};
            infl_wdata = next_q;
        end
        else if (accept && func == FUNC_WRITE && cell_ok && layer_ok)
        begin
            infl_we = 1'b1;
            used_we = 1'b1;
        end
    end

    assign infl_raddr = (state_reg == ST_SCAN) ? {nidx, layer_reg} : {cell_addr, layer_addr};
    assign used_raddr = (state_reg == ST_SCAN) ? nidx : cell_addr;

    always_ff @(posedge clk)
    begin
        if (infl_we)
            infl_mem[infl_waddr] <= infl_wdata;
        infl_q <= infl_mem[infl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= used_wdata;
        used_q <= used_mem[used_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
            next_mem[idx_reg] <= blend_res;
        next_q <= next_mem[idx_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_cells_reg       <= 5'd16;
            y_cells_reg       <= 5'd16;
            z_cells_reg       <= 5'd16;
            inertia_reg       <= 16'd16384;
            weight_face_reg   <= 16'd16384;
            weight_edge_reg   <= 16'd12417;
            weight_corner_reg <= 16'd10403;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_CELLS:       x_cells_reg       <= cfg_data[4:0];
                REG_Y_CELLS:       y_cells_reg       <= cfg_data[4:0];
                REG_Z_CELLS:       z_cells_reg       <= cfg_data[4:0];
                REG_INERTIA:       inertia_reg       <= cfg_data;
                REG_WEIGHT_FACE:   weight_face_reg   <= cfg_data;
                REG_WEIGHT_EDGE:   weight_edge_reg   <= cfg_data;
                REG_WEIGHT_CORNER: weight_corner_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && func == FUNC_PASS && layer_ok)
                    state_next = ST_SCAN;
            ST_CLEAR:
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            ST_SCAN:
                if (nb_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (s2_last_reg)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
                state_next = cell_last ? ST_COPY : ST_SCAN;
            ST_COPY:
                if (cell_last)
                    state_next = ST_FIN;
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            idx_reg     <= '0;
            dxc_reg     <= '0;
            dyc_reg     <= '0;
            dzc_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            cp_vld_reg  <= 1'b0;
            rdv_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            pos_reg     <= '0;
            neg_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            rdv_reg <= accept && func == FUNC_READ;
            fin_reg <= (state_reg == ST_FIN) || (accept && func == FUNC_PASS && !layer_ok);

            if (accept)
            begin
                x_reg   <= '0;
                y_reg   <= '0;
                z_reg   <= '0;
                idx_reg <= '0;
                dxc_reg <= '0;
                dyc_reg <= '0;
                dzc_reg <= '0;
            end

            // neighbor walk, x fastest
            if (state_reg == ST_SCAN)
            begin
                dxc_reg <= (dxc_reg == 2'd2) ? 2'd0 : dxc_reg + 2'd1;
                if (dxc_reg == 2'd2)
                begin
                    dyc_reg <= (dyc_reg == 2'd2) ? 2'd0 : dyc_reg + 2'd1;
                    if (dyc_reg == 2'd2)
                        dzc_reg <= (dzc_reg == 2'd2) ? 2'd0 : dzc_reg + 2'd1;
                end
            end

            // cell walk, shared by the update and the copy sweep
            if (state_reg == ST_SUM || state_reg == ST_COPY)
            begin
                if (cell_last)
                begin
                    x_reg   <= '0;
                    y_reg   <= '0;
                    z_reg   <= '0;
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(x_reg) + 1 == 32'(nx_reg))
                    begin
                        x_reg <= '0;
                        if (32'(y_reg) + 1 == 32'(ny_reg))
                        begin
                            y_reg <= '0;
                            z_reg <= z_reg + 1'b1;
                        end
                        else
                            y_reg <= y_reg + 1'b1;
                    end
                    else
                        x_reg <= x_reg + 1'b1;
                end
            end

            s1_vld_reg  <= (state_reg == ST_SCAN) && nb_in;
            s1_last_reg <= (state_reg == ST_SCAN) && nb_last;
            s2_vld_reg  <= s1_vld_reg && used_q;
            s2_last_reg <= s1_last_reg;

            if (state_reg == ST_SUM)
            begin
                pos_reg <= '0;
                neg_reg <= '0;
            end
            else if (s2_vld_reg)
            begin
                if (wv > pos_reg)
                    pos_reg <= wv;
                if (wv < neg_reg)
                    neg_reg <= wv;
            end

            cp_vld_reg <= (state_reg == ST_COPY);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nx_reg          <= nx_eff;
            ny_reg          <= ny_eff;
            nz_reg          <= nz_eff;
            plane_reg       <= (CW + 1)'(nx_eff) * (CW + 1)'(ny_eff);
            layer_reg       <= layer_addr;
            wf_reg          <= clamp_q15(weight_face_reg);
            we_reg          <= clamp_q15(weight_edge_reg);
            wc_reg          <= clamp_q15(weight_corner_reg);
            in_reg          <= clamp_q15(inertia_reg);
            rd_cell_ok_reg  <= cell_ok;
            rd_layer_ok_reg <= layer_ok;
        end
        if (state_reg == ST_SCAN)
        begin
            s1_far_reg <= far;
            s1_ctr_reg <= (far == 2'd0);
        end
        prod_reg <= infl_q * $signed({1'b0, w_sel});
        if (s1_ctr_reg)
        begin
            old_reg   <= infl_q;
            cused_reg <= used_q;
        end
        cp_addr_reg <= idx_reg;
    end

    assign bin.old_value = old_reg;
    assign bin.pos       = pos_reg;
    assign bin.neg       = neg_reg;
    assign bin.cell_used = cused_reg;

    gip_blend u_blend
    (
        .clk       (clk),
        .go        (state_reg == ST_MUL),
        .bin       (bin),
        .inertia_q (in_reg),
        .result    (blend_res)
    );

    // result ports
    assign done       = rdv_reg || fin_reg;
    assign kind       = fin_reg ? KIND_PASS : KIND_READ;
    assign read_value = (rdv_reg && rd_cell_ok_reg && rd_layer_ok_reg) ? infl_q : '0;
    assign read_used  = rdv_reg && rd_cell_ok_reg && used_q;

    // checks
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(rdv_reg && fin_reg))
        else $error("read and pass results in one cycle");

    a_sum_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> $past(state_reg) == ST_MUL)
        else $error("blend result used without products");

    a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
        cp_vld_reg |-> $past(state_reg) == ST_COPY)
        else $error("copy write outside copy sweep");

    a_pass_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_PASS) |=> (busy || done))
        else $error("pass item neither started nor finished");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        s2_last_reg |-> state_reg == ST_DRAIN)
        else $error("neighbor pipeline out of step with sequencer");

endmodule

FILE: rtl/gip_blend.sv
`timescale 1ns / 1ps
// Inertia blend of one cell: registered products, then sum, floor shift and clamp; zero for an unused cell.
// Depends on gip_pkg.
module gip_blend
    import gip_pkg::*;
(
    input  logic        clk,
    input  logic        go,
    input  blend_in_t   bin,
    input  logic [15:0] inertia_q,
    output val_t        result
);

    logic signed [32:0] prod_a_reg;
    logic signed [35:0] prod_b_reg;
    logic               used_reg;
    logic signed [18:0] pn_sum;
    logic signed [16:0] in_s;
    logic signed [16:0] rest_s;
    logic signed [36:0] total;
    logic signed [21:0] shifted;

    assign pn_sum = 19'(bin.pos) + 19'(bin.neg);
    assign in_s   = $signed({1'b0, inertia_q});
    assign rest_s = 17'sd32768 - in_s;

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_a_reg <= bin.old_value * in_s;
            prod_b_reg <= pn_sum * rest_s;
            used_reg   <= bin.cell_used;
        end
    end

    assign total   = 37'(prod_a_reg) + 37'(prod_b_reg);
    assign shifted = total[36:15];   // floor divide by 2^15

    always_comb
    begin
        if (!used_reg)
            result = '0;
        else if (shifted > 22'sd16384)
            result = 16'sd16384;
        else if (shifted < -22'sd16384)
            result = -16'sd16384;
        else
            result = shifted[15:0];
    end

endmodule
